// ----- hw/rtl/string_keyed_hash_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// string_keyed_hash_accumulator_assert.svh
// Assertion macros shared by the checker of the hash accumulator.
// ----------------------------------------------------------------------------
`ifndef STRING_KEYED_HASH_ACCUMULATOR_ASSERT_SVH
`define STRING_KEYED_HASH_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SKHA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SKHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/skha_pkg.sv -----
// ----------------------------------------------------------------------------
// skha_pkg
// Types, sizes and helpers of the string keyed hash accumulator.
// ----------------------------------------------------------------------------
package skha_pkg;

	// table geometry
	localparam int SLOTS   = 4096;
	localparam int KEY_LEN = 64;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int POS_W   = $clog2(KEY_LEN);
	localparam int LEN_W   = $clog2(KEY_LEN + 1);
	localparam int KADDR_W = $clog2(SLOTS * KEY_LEN);
	localparam int USED_W  = $clog2(SLOTS + 1);

	// hash constants
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [7:0]  SEP_CHAR  = 8'h3B;

	// request kinds
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {
		OUT_INSERTED = 2'd0,
		OUT_ACCUM    = 2'd1,
		OUT_DROPPED  = 2'd2,
		OUT_READ     = 2'd3
	} outcome_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_NEXT,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_ACC,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_READ,
		ST_RESP
	} state_t;

	// memory port requests toward the table
	typedef struct packed {
		logic               tot_we;
		logic [SLOT_W-1:0]  tot_addr;
		logic [63:0]        tot_wd;
		logic               len_we;
		logic [SLOT_W-1:0]  len_addr;
		logic [POS_W-1:0]   len_wd;
		logic               key_we;
		logic [KADDR_W-1:0] key_addr;
		logic [7:0]         key_wd;
	} tbl_req_t;

	// registered read data from the table
	typedef struct packed {
		logic [63:0]      tot;
		logic [POS_W-1:0] len;
		logic [7:0]       key;
	} tbl_rsp_t;

	// commands to the key unit
	typedef struct packed {
		logic             absorb;
		logic [7:0]       key_byte;
		logic             clear;
		logic [POS_W-1:0] rd_addr;
	} key_cmd_t;

	// kept prefix of the key being assembled
	typedef struct packed {
		logic [POS_W-1:0]  n;
		logic [SLOT_W-1:0] h;
		logic [7:0]        buf_rd;
	} key_info_t;

	// pending result
	typedef struct packed {
		outcome_t    outcome;
		logic [11:0] idx;
		logic [63:0] total;
		logic [5:0]  klen;
		logic [7:0]  kbyte;
	} result_t;

	// flat address of one stored key byte
	function automatic logic [KADDR_W-1:0] key_addr(
		input logic [SLOT_W-1:0] slot,
		input logic [POS_W-1:0]  pos
	);
		logic [KADDR_W-1:0] base;
		base = KADDR_W'(slot) * KADDR_W'(KEY_LEN);
		return base + KADDR_W'(pos);
	endfunction

endpackage

// ----- hw/rtl/skha_if.sv -----
// ----------------------------------------------------------------------------
// skha_if
// Request and response channels of the hash accumulator.
// ----------------------------------------------------------------------------
interface skha_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  key_byte;
	logic        key_last;
	logic [31:0] sample_bytes;
	logic [11:0] read_slot;
	logic [5:0]  read_pos;

	modport source (output valid, kind, key_byte, key_last, sample_bytes, read_slot,
		read_pos, input ready);
	modport sink (input valid, kind, key_byte, key_last, sample_bytes, read_slot,
		read_pos, output ready);
endinterface

interface skha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [11:0] slot_index;
	logic [12:0] entries_used;
	logic [63:0] dropped_total;
	logic [63:0] entry_total;
	logic [5:0]  entry_key_length;
	logic [7:0]  entry_key_byte;

	modport source (output valid, outcome, slot_index, entries_used, dropped_total,
		entry_total, entry_key_length, entry_key_byte, input ready);
	modport sink (input valid, outcome, slot_index, entries_used, dropped_total,
		entry_total, entry_key_length, entry_key_byte, output ready);
endinterface

// ----- hw/rtl/skha_key_unit.sv -----
// ----------------------------------------------------------------------------
// skha_key_unit
// Absorbs key bytes: buffer, FNV-1a hash and last separator tracking.
// ----------------------------------------------------------------------------
module skha_key_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  skha_pkg::key_cmd_t  cmd,
	output skha_pkg::key_info_t info
);

	logic [7:0]                  buf_mem [skha_pkg::KEY_LEN];
	logic [7:0]                  buf_rd_q;
	logic [skha_pkg::LEN_W-1:0]  len_q;
	logic [31:0]                 hash_q;
	logic [31:0]                 sep_hash_q;
	logic [skha_pkg::POS_W-1:0]  sep_pos_q;
	logic                        is_sep;
	logic                        store;
	logic [31:0]                 hash_x;

	// separator at a cut-able position, byte kept below the length limit
	assign is_sep = (len_q >= skha_pkg::LEN_W'(1))
		&& (len_q <= skha_pkg::LEN_W'(skha_pkg::KEY_LEN - 1))
		&& (cmd.key_byte == skha_pkg::SEP_CHAR);
	assign store  = len_q < skha_pkg::LEN_W'(skha_pkg::KEY_LEN - 1);
	assign hash_x = hash_q ^ {24'd0, cmd.key_byte};

	// incoming key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			hash_q     <= skha_pkg::FNV_BASIS;
			sep_hash_q <= skha_pkg::FNV_BASIS;
			sep_pos_q  <= '0;
		end else if (cmd.clear) begin
			len_q      <= '0;
			hash_q     <= skha_pkg::FNV_BASIS;
			sep_hash_q <= skha_pkg::FNV_BASIS;
			sep_pos_q  <= '0;
		end else if (cmd.absorb) begin
			if (is_sep) begin
				sep_pos_q  <= skha_pkg::POS_W'(len_q);
				sep_hash_q <= hash_q;
			end
			if (store) begin
				hash_q <= hash_x * skha_pkg::FNV_PRIME;
			end
			if (len_q < skha_pkg::LEN_W'(skha_pkg::KEY_LEN)) begin
				len_q <= len_q + skha_pkg::LEN_W'(1);
			end
		end
	end

	// key byte buffer, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.absorb && store) begin
			buf_mem[skha_pkg::POS_W'(len_q)] <= cmd.key_byte;
		end
		buf_rd_q <= buf_mem[cmd.rd_addr];
	end

	// kept prefix length and its hash
	always_comb begin
		info.buf_rd = buf_rd_q;
		if (len_q >= skha_pkg::LEN_W'(skha_pkg::KEY_LEN)) begin
			if (sep_pos_q != '0) begin
				info.n = sep_pos_q;
				info.h = sep_hash_q[skha_pkg::SLOT_W-1:0];
			end else begin
				info.n = skha_pkg::POS_W'(skha_pkg::KEY_LEN - 1);
				info.h = hash_q[skha_pkg::SLOT_W-1:0];
			end
		end else begin
			info.n = skha_pkg::POS_W'(len_q);
			info.h = hash_q[skha_pkg::SLOT_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/skha_table.sv -----
// ----------------------------------------------------------------------------
// skha_table
// Slot totals, key lengths and key bytes, each a single port memory.
// ----------------------------------------------------------------------------
module skha_table (
	input  logic               clk,
	input  skha_pkg::tbl_req_t req,
	output skha_pkg::tbl_rsp_t rsp
);

	logic [63:0]                tot_mem [skha_pkg::SLOTS];
	logic [skha_pkg::POS_W-1:0] len_mem [skha_pkg::SLOTS];
	logic [7:0]                 key_mem [skha_pkg::SLOTS * skha_pkg::KEY_LEN];

	// slot totals
	always_ff @(posedge clk) begin
		if (req.tot_we) begin
			tot_mem[req.tot_addr] <= req.tot_wd;
		end
		rsp.tot <= tot_mem[req.tot_addr];
	end

	// key lengths
	always_ff @(posedge clk) begin
		if (req.len_we) begin
			len_mem[req.len_addr] <= req.len_wd;
		end
		rsp.len <= len_mem[req.len_addr];
	end

	// key bytes
	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.key_addr] <= req.key_wd;
		end
		rsp.key <= key_mem[req.key_addr];
	end

endmodule

// ----- hw/rtl/string_keyed_hash_accumulator.sv -----
// ----------------------------------------------------------------------------
// string_keyed_hash_accumulator
// FNV-1a hashed, linearly probed table of byte-string keys and 64-bit totals.
// ----------------------------------------------------------------------------
// Usage:
// req carries one request per handshake: a key byte (kind 0) or a slot read
// (kind 1). The last key byte carries sample_bytes. rsp returns one result per
// last key byte and per read; other key bytes give none.
// A key byte that is not last leaves the block idle, so such bytes go back to back.
// A read passes through ST_READ and ST_RESP and then shows on rsp; req.ready
// returns in that same cycle, so a read is not taken while another is in flight.
// A last key byte is hashed and slots are probed from the home slot on: each
// is read (ST_PROBE_RD), checked (ST_PROBE_CHK) and passed over (ST_NEXT)
// unless it is empty (claimed, key copied in) or holds the same key (added).
// A full table reports the drop after every slot has been probed. The single
// port memories give each compared or copied byte its own read state.
// After reset the totals memory is swept to zero, one slot per cycle, over
// all SLOTS (4096) slots, and req.ready stays low meanwhile.
// A result waits in an output register while rsp.ready is low; the block
// still takes key bytes, but holds a new result until the register is free.
// ----------------------------------------------------------------------------
module string_keyed_hash_accumulator (
	input  logic       clk,
	input  logic       arst_n,
	skha_req_if.sink   req,
	skha_rsp_if.source rsp
);

	skha_pkg::state_t            state_q, state_d;
	skha_pkg::tbl_req_t          tbl_req;
	skha_pkg::tbl_rsp_t          tbl_rsp;
	skha_pkg::key_cmd_t          key_cmd;
	skha_pkg::key_info_t         key_info;
	skha_pkg::result_t           res_q, out_q;

	logic [skha_pkg::SLOT_W-1:0] clr_q;
	logic [skha_pkg::SLOT_W-1:0] slot_q;
	logic [skha_pkg::SLOT_W-1:0] probe_cnt_q;
	logic [skha_pkg::POS_W-1:0]  j_q;
	logic [31:0]                 amt_q;
	logic [63:0]                 tot_q;
	logic [skha_pkg::USED_W-1:0] used_q;
	logic [skha_pkg::USED_W-1:0] out_used_q;
	logic [63:0]                 drop_q;
	logic [63:0]                 out_drop_q;
	logic [11:0]                 rs_q;
	logic [5:0]                  rp_q;
	logic                        rs_ok_q;
	logic                        is_key_q;
	logic                        out_valid_q;

	logic                        req_fire;
	logic                        out_free;
	logic [63:0]                 acc_sum;
	logic                        last_probe;
	logic                        cmp_done;

	assign req_fire   = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign acc_sum    = tot_q + {32'd0, amt_q};
	assign last_probe = probe_cnt_q == skha_pkg::SLOT_W'(skha_pkg::SLOTS - 1);
	assign cmp_done   = j_q == key_info.n;

	skha_key_unit u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (key_cmd),
		.info   (key_info)
	);

	skha_table u_tbl (
		.clk (clk),
		.req (tbl_req),
		.rsp (tbl_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skha_pkg::ST_CLEAR: begin
				if (clr_q == skha_pkg::SLOT_W'(skha_pkg::SLOTS - 1)) begin
					state_d = skha_pkg::ST_IDLE;
				end
			end
			skha_pkg::ST_IDLE: begin
				if (req_fire) begin
					if (req.kind == skha_pkg::KIND_READ) begin
						state_d = skha_pkg::ST_READ;
					end else if (req.key_last) begin
						state_d = skha_pkg::ST_HASH;
					end
				end
			end
			skha_pkg::ST_HASH:     state_d = skha_pkg::ST_PROBE_RD;
			skha_pkg::ST_PROBE_RD: state_d = skha_pkg::ST_PROBE_CHK;
			skha_pkg::ST_PROBE_CHK: begin
				if (tbl_rsp.tot == 64'd0) begin
					state_d = skha_pkg::ST_COPY_RD;
				end else if (tbl_rsp.len == key_info.n) begin
					state_d = skha_pkg::ST_CMP_RD;
				end else begin
					state_d = skha_pkg::ST_NEXT;
				end
			end
			skha_pkg::ST_NEXT: begin
				state_d = last_probe ? skha_pkg::ST_RESP : skha_pkg::ST_PROBE_RD;
			end
			skha_pkg::ST_CMP_RD: begin
				state_d = cmp_done ? skha_pkg::ST_ACC : skha_pkg::ST_CMP_CHK;
			end
			skha_pkg::ST_CMP_CHK: begin
				state_d = (key_info.buf_rd == tbl_rsp.key) ? skha_pkg::ST_CMP_RD
					: skha_pkg::ST_NEXT;
			end
			skha_pkg::ST_ACC:     state_d = skha_pkg::ST_RESP;
			skha_pkg::ST_COPY_RD: begin
				state_d = cmp_done ? skha_pkg::ST_RESP : skha_pkg::ST_COPY_WR;
			end
			skha_pkg::ST_COPY_WR: state_d = skha_pkg::ST_COPY_RD;
			skha_pkg::ST_READ:    state_d = skha_pkg::ST_RESP;
			skha_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = skha_pkg::ST_IDLE;
				end
			end
			default: state_d = skha_pkg::ST_CLEAR;
		endcase
	end

	// memory requests and key unit commands
	always_comb begin
		tbl_req          = '0;
		tbl_req.tot_addr = slot_q;
		tbl_req.len_addr = slot_q;
		tbl_req.key_addr = skha_pkg::key_addr(slot_q, j_q);
		tbl_req.tot_wd   = acc_sum;
		tbl_req.len_wd   = key_info.n;
		tbl_req.key_wd   = key_info.buf_rd;
		key_cmd.absorb   = req_fire && (req.kind == skha_pkg::KIND_KEY);
		key_cmd.key_byte = req.key_byte;
		key_cmd.clear    = (state_q == skha_pkg::ST_RESP) && out_free && is_key_q;
		key_cmd.rd_addr  = j_q;
		req.ready        = state_q == skha_pkg::ST_IDLE;
		case (state_q)
			skha_pkg::ST_CLEAR: begin
				tbl_req.tot_we   = 1'b1;
				tbl_req.tot_addr = clr_q;
				tbl_req.tot_wd   = 64'd0;
			end
			skha_pkg::ST_IDLE: begin
				tbl_req.tot_addr = skha_pkg::SLOT_W'(req.read_slot);
				tbl_req.len_addr = skha_pkg::SLOT_W'(req.read_slot);
				tbl_req.key_addr = skha_pkg::key_addr(skha_pkg::SLOT_W'(req.read_slot),
					skha_pkg::POS_W'(req.read_pos));
			end
			skha_pkg::ST_PROBE_CHK: begin
				// empty slot: claim it now, key bytes follow
				if (tbl_rsp.tot == 64'd0) begin
					tbl_req.tot_we = 1'b1;
					tbl_req.tot_wd = {32'd0, amt_q};
					tbl_req.len_we = 1'b1;
				end
			end
			skha_pkg::ST_ACC: begin
				tbl_req.tot_we = 1'b1;
			end
			skha_pkg::ST_COPY_WR: begin
				tbl_req.key_we = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skha_pkg::ST_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
			is_key_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			// output register loads a new result or drains
			if ((state_q == skha_pkg::ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				skha_pkg::ST_CLEAR: begin
					clr_q <= clr_q + skha_pkg::SLOT_W'(1);
				end
				skha_pkg::ST_IDLE: begin
					amt_q   <= req.sample_bytes;
					rs_q    <= req.read_slot;
					rp_q    <= req.read_pos;
					rs_ok_q <= 32'(req.read_slot) < 32'(skha_pkg::SLOTS);
					is_key_q <= req.kind == skha_pkg::KIND_KEY;
				end
				skha_pkg::ST_HASH: begin
					slot_q      <= key_info.h;
					probe_cnt_q <= '0;
				end
				skha_pkg::ST_PROBE_CHK: begin
					tot_q <= tbl_rsp.tot;
					j_q   <= '0;
					if (tbl_rsp.tot == 64'd0) begin
						if (amt_q != 32'd0) begin
							used_q <= used_q + skha_pkg::USED_W'(1);
						end
						res_q.outcome <= skha_pkg::OUT_INSERTED;
						res_q.idx     <= 12'(slot_q);
						res_q.total   <= {32'd0, amt_q};
						res_q.klen    <= 6'(key_info.n);
						res_q.kbyte   <= 8'd0;
					end
				end
				skha_pkg::ST_NEXT: begin
					slot_q      <= slot_q + skha_pkg::SLOT_W'(1);
					probe_cnt_q <= probe_cnt_q + skha_pkg::SLOT_W'(1);
					if (last_probe) begin
						drop_q        <= drop_q + {32'd0, amt_q};
						res_q.outcome <= skha_pkg::OUT_DROPPED;
						res_q.idx     <= 12'd0;
						res_q.total   <= 64'd0;
						res_q.klen    <= 6'(key_info.n);
						res_q.kbyte   <= 8'd0;
					end
				end
				skha_pkg::ST_CMP_CHK: begin
					j_q <= j_q + skha_pkg::POS_W'(1);
				end
				skha_pkg::ST_ACC: begin
					// a total that wraps to zero frees its slot
					if ((acc_sum == 64'd0) && (used_q != '0)) begin
						used_q <= used_q - skha_pkg::USED_W'(1);
					end
					res_q.outcome <= skha_pkg::OUT_ACCUM;
					res_q.idx     <= 12'(slot_q);
					res_q.total   <= acc_sum;
					res_q.klen    <= 6'(key_info.n);
					res_q.kbyte   <= 8'd0;
				end
				skha_pkg::ST_COPY_WR: begin
					j_q <= j_q + skha_pkg::POS_W'(1);
				end
				skha_pkg::ST_READ: begin
					res_q.outcome <= skha_pkg::OUT_READ;
					res_q.idx     <= rs_q;
					if (rs_ok_q && (tbl_rsp.tot != 64'd0)) begin
						res_q.total <= tbl_rsp.tot;
						res_q.klen  <= 6'(tbl_rsp.len);
						res_q.kbyte <= (32'(rp_q) < 32'(tbl_rsp.len)) ? tbl_rsp.key : 8'd0;
					end else begin
						res_q.total <= 64'd0;
						res_q.klen  <= 6'd0;
						res_q.kbyte <= 8'd0;
					end
				end
				skha_pkg::ST_RESP: begin
					if (out_free) begin
						out_q      <= res_q;
						out_used_q <= used_q;
						out_drop_q <= drop_q;
					end
				end
				default: ;
			endcase
		end
	end

	// response channel
	assign rsp.valid            = out_valid_q;
	assign rsp.outcome          = out_q.outcome;
	assign rsp.slot_index       = out_q.idx;
	assign rsp.entries_used     = 13'(out_used_q);
	assign rsp.dropped_total    = out_drop_q;
	assign rsp.entry_total      = out_q.total;
	assign rsp.entry_key_length = out_q.klen;
	assign rsp.entry_key_byte   = out_q.kbyte;

endmodule

// ----- hw/rtl/skha_checker.sv -----
// ----------------------------------------------------------------------------
// skha_checker
// Port-level checks of the hash accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "string_keyed_hash_accumulator_assert.svh"

module skha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_kind,
	input logic        req_key_last,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_outcome,
	input logic [11:0] rsp_slot_index,
	input logic [63:0] rsp_entry_total
);

	// a stalled response stays up
	`SKHA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// a stalled response keeps its total
	`SKHA_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_entry_total))

	// a request that yields a result closes the request side
	`SKHA_ASSERT_NEXT(a_busy_after_step,
		req_valid && req_ready && (req_kind || req_key_last), !req_ready)

	// a dropped amount reports no slot and no total
	`SKHA_ASSERT_NOW(a_drop_fields, rsp_valid && (rsp_outcome == skha_pkg::OUT_DROPPED),
		(rsp_slot_index == 12'd0) && (rsp_entry_total == 64'd0))

endmodule

bind string_keyed_hash_accumulator skha_checker u_skha_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_kind        (req.kind),
	.req_key_last    (req.key_last),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_outcome     (rsp.outcome),
	.rsp_slot_index  (rsp.slot_index),
	.rsp_entry_total (rsp.entry_total)
);
